### hw/rtl/sslt_pkg.sv
// ----------------------------------------------------------------------------
// sslt_pkg
// Shared types and constants for the source sequence loss tracker.
// ----------------------------------------------------------------------------
package sslt_pkg;

  localparam logic [23:0] RADIO_STATUS_A = 24'd109;
  localparam logic [23:0] RADIO_STATUS_B = 24'd166;
  localparam logic [14:0] Q8_HUNDRED     = 15'd25600;
  localparam logic [31:0] TIMEOUT_RESET  = 32'd10000;

  // packets per loss window; a power of two so the window test is a mask
  localparam int LOSS_WINDOW = 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

### hw/rtl/sslt_div.sv
// ----------------------------------------------------------------------------
// sslt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sslt_div (
  input  logic              clk,
  input  logic              rst,
  input  sslt_pkg::div_req_t req,
  output sslt_pkg::div_rsp_t rsp
);
  import sslt_pkg::*;

  logic        busy;
  logic        done_r;
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [17:0] rem;
  logic [16:0] den;
  logic [17:0] trial;

  assign trial = {rem[16:0], quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done_r, quo};

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy) else $error("done while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 6'd0) else $error("busy with zero count");
`endif

endmodule

### hw/rtl/source_sequence_loss_tracker.sv
// ----------------------------------------------------------------------------
// source_sequence_loss_tracker
// Per-source packet counters, sequence gap loss and recent loss percentage.
// ----------------------------------------------------------------------------
// A packet transaction steps from acceptance through the memory read, the
// calc step and the update step to its output step, with a divide step
// added when it closes a loss window: the percentage comes from a shared
// restoring divider producing one quotient bit per cycle, after a rounding
// step. A sweep transaction visits the table entries one entry per cycle.
// State lives in per-source memories with one read and one write port; valid
// bits are flip-flops cleared by reset. The loss window is a power-of-two
// constant. The block takes one transaction at a time; a finished result
// waits in the output register while the next transaction is taken, and that
// one holds in its output step until the earlier result is taken.
module source_sequence_loss_tracker #(
  parameter int SOURCES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] req_type
  input  logic        s_tuser,
  // [7:0] source_id, [15:8] sequence_req, [39:16] message_id, [71:40] now_ms
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] new_source, [1] percent_updated
  output logic [1:0]  m_tuser,
  // [31:0] received_count, [63:32] lost_count, [78:64] loss_percent_q8,
  // [87:79] removed_count
  output logic [87:0] m_tdata
);
  import sslt_pkg::*;

  localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int WW = (LOSS_WINDOW > 1) ? $clog2(LOSS_WINDOW) : 1;

  state_t state;
  logic [31:0] timeout;
  logic        req;
  logic [7:0]  sid, seq;
  logic [23:0] msg;
  logic [31:0] now;
  logic [1:0]  seen;
  logic [SOURCES-1:0] valid;

  // per-entry memories
  logic [7:0]  m_seq  [SOURCES];
  logic [31:0] m_rx   [SOURCES];
  logic [31:0] m_lost [SOURCES];
  logic [15:0] m_rrx  [SOURCES];
  logic [15:0] m_rlost[SOURCES];
  logic [14:0] m_pct  [SOURCES];
  logic [31:0] m_ts   [SOURCES];

  logic [IW-1:0] raddr, waddr;
  logic          wen;
  logic [7:0]  r_seq, w_seq;
  logic [31:0] r_rx, r_lost, r_ts, w_rx, w_lost;
  logic [15:0] r_rrx, r_rlost, w_rrx, w_rlost;
  logic [14:0] r_pct, w_pct;

  always_ff @(posedge clk) begin
    if (wen) begin
      m_seq[waddr]   <= w_seq;
      m_rx[waddr]    <= w_rx;
      m_lost[waddr]  <= w_lost;
      m_rrx[waddr]   <= w_rrx;
      m_rlost[waddr] <= w_rlost;
      m_pct[waddr]   <= w_pct;
      m_ts[waddr]    <= now;
    end
    r_seq   <= m_seq[raddr];
    r_rx    <= m_rx[raddr];
    r_lost  <= m_lost[raddr];
    r_rrx   <= m_rrx[raddr];
    r_rlost <= m_rlost[raddr];
    r_pct   <= m_pct[raddr];
    r_ts    <= m_ts[raddr];
  end

  // working values
  logic        created, updated, gap_on;
  logic [8:0]  removed;
  logic [IW:0] scan;
  logic [IW:0] scan_d;
  logic        scan_act;
  logic [7:0]  last_seq, gap, valid_gap;
  logic        do_gap;
  logic [31:0] rx1, lost1;
  logic [15:0] rrx1, rlost1;
  logic [32:0] g_lost;
  logic [16:0] g_rlost;
  logic [31:0] lost_sum;
  logic [15:0] rlost_sum;
  logic [31:0] pnum;
  logic [16:0] pden;
  logic        div_start, div_run;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [14:0] pct_q;
  logic        in_tab;
  logic        out_load;

  sslt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_tab = ({24'd0, sid} < 32'(SOURCES));

  // a new entry starts from sequence zero
  always_comb begin
    last_seq = gap_on ? r_seq : 8'd0;
    if (last_seq > seq)      gap = seq + 8'd255 - last_seq;
    else if (last_seq < seq) gap = seq - last_seq - 8'd1;
    else                     gap = 8'd0;
    do_gap    = (msg != RADIO_STATUS_A) && (msg != RADIO_STATUS_B) && (seen == 2'd2);
    valid_gap = do_gap ? gap : 8'd0;
    g_lost    = {1'b0, lost1} + {25'd0, valid_gap};
    g_rlost   = {1'b0, rlost1} + {9'd0, valid_gap};
    lost_sum  = g_lost[32] ? 32'hFFFF_FFFF : g_lost[31:0];
    rlost_sum = g_rlost[16] ? 16'hFFFF : g_rlost[15:0];
  end

  assign s_tready = (state == S_IDLE);
  assign waddr    = sid[IW-1:0];
  assign raddr    = (state == S_SWEEP) ? scan[IW-1:0] : sid[IW-1:0];
  assign dreq     = {div_start, pnum, pden};
  assign pct_q    = (drsp.quo > {17'd0, Q8_HUNDRED}) ? Q8_HUNDRED : drsp.quo[14:0];
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      timeout   <= TIMEOUT_RESET;
      seen      <= '0;
      valid     <= '0;
      m_tvalid  <= 1'b0;
      wen       <= 1'b0;
      div_start <= 1'b0;
      div_run   <= 1'b0;
      scan_act  <= 1'b0;
    end else begin
      wen       <= 1'b0;
      div_start <= 1'b0;
      if (cfg_we) timeout <= cfg_wdata;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            req <= s_tuser;
            sid <= s_tdata[7:0];
            seq <= s_tdata[15:8];
            msg <= s_tdata[39:16];
            now <= s_tdata[71:40];
            removed <= '0;
            scan <= '0;
            scan_act <= 1'b0;
            state <= s_tuser ? S_SWEEP : S_READ;
          end
        end
        S_READ: state <= S_CALC;  // memory read latency
        S_CALC: begin
          if (!in_tab) begin
            created <= 1'b0;
            updated <= 1'b0;
            w_rx <= '0; w_lost <= '0; w_pct <= '0;
            state <= S_OUT;
          end else begin
            created <= !valid[sid[IW-1:0]];
            valid[sid[IW-1:0]] <= 1'b1;
            if (seen != 2'd2) seen <= seen + 2'd1;
            if (valid[sid[IW-1:0]]) begin
              rx1 <= (r_rx == '1) ? r_rx : r_rx + 32'd1;
              rrx1 <= (r_rrx == '1) ? r_rrx : r_rrx + 16'd1;
              lost1 <= r_lost; rlost1 <= r_rlost; w_pct <= r_pct;
              gap_on <= 1'b1;
            end else begin
              rx1 <= 32'd1; rrx1 <= 16'd1;
              lost1 <= '0; rlost1 <= '0; w_pct <= '0;
              gap_on <= 1'b0;
            end
            state <= S_DIV;
          end
        end
        S_DIV: begin
          w_seq   <= seq;
          w_rx    <= rx1;
          w_rrx   <= rrx1;
          w_lost  <= lost_sum;
          w_rlost <= rlost_sum;
          updated <= 1'b0;
          if (do_gap && rx1[WW-1:0] == '0) begin
            pden  <= {1'b0, rrx1} + {1'b0, rlost_sum};
            pnum  <= {16'd0, rlost_sum} * {17'd0, Q8_HUNDRED};
            state <= S_WRITE;
          end else begin
            wen   <= 1'b1;
            state <= S_OUT;
          end
        end
        S_WRITE: begin
          // add den/2 once, then divide
          if (!div_run) begin
            pnum <= pnum + {16'd0, pden[16:1]};
            div_run <= 1'b1;
            div_start <= 1'b1;
          end else if (drsp.done) begin
            w_pct <= pct_q;
            w_rrx <= '0;
            w_rlost <= '0;
            updated <= 1'b1;
            div_run <= 1'b0;
            wen <= 1'b1;
            state <= S_OUT;
          end
        end
        S_SWEEP: begin
          // pipelined scan: address scan, data checked in the next cycle
          if (scan_act && valid[scan_d[IW-1:0]] && seen != 2'd0
              && (now - r_ts) > timeout) begin
            valid[scan_d[IW-1:0]] <= 1'b0;
            removed <= removed + 9'd1;
          end
          scan_d   <= scan;
          scan_act <= (scan < (IW+1)'(SOURCES));
          if (scan < (IW+1)'(SOURCES)) scan <= scan + 1'b1;
          else if (!scan_act || scan_d == (IW+1)'(SOURCES)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (req) begin
              m_tuser <= 2'b00;
              m_tdata <= {removed, 79'd0};
            end else if (!in_tab) begin
              m_tuser <= 2'b00;
              m_tdata <= '0;
            end else begin
              m_tuser <= {updated, created};
              m_tdata <= {9'd0, w_pct, w_lost, w_rx};
            end
            updated <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_seen_max: assert property (@(posedge clk) disable iff (rst)
    seen != 2'd3) else $error("packet count overflow");
  a_div_sweep: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !req) else $error("divider started on sweep");
  a_wen_pkt: assert property (@(posedge clk) disable iff (rst)
    wen |-> !req) else $error("table write during sweep");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for source_sequence_loss_tracker: packet and sweep
// transactions are predicted in-bench and each result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sslt_pkg::*;

  localparam int SRC = 256;
  localparam int WIN = 32;
  localparam bit REQ_PACKET = 1'b0;
  localparam bit REQ_SWEEP  = 1'b1;
  localparam longint LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [8:0]  removed;
    logic [14:0] pct;
    logic [31:0] lost;
    logic [31:0] rcvd;
    logic        updated;
    logic        created;
  } stats_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic        s_tuser = 0;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [1:0]  m_tuser;
  logic [87:0] m_tdata;

  source_sequence_loss_tracker #(.SOURCES(SRC)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [31:0] timeout_ms;
  bit          valid_tab[SRC];
  logic [7:0]  last_seq[SRC];
  logic [31:0] rcvd_tot[SRC];
  logic [31:0] lost_tot[SRC];
  logic [15:0] rec_rcvd[SRC];
  logic [15:0] rec_lost[SRC];
  logic [14:0] pct_tab[SRC];
  logic [31:0] seen_ms[SRC];
  int          pkts_seen;

  stats_t expected_stats[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_off = 0;
  longint cycles = 0;

  function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] add_sat16(logic [15:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + {1'b0, b};
    return (s > 33'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic stats_t predict_stats(bit req, logic [7:0] id, logic [7:0] seq,
                                           logic [23:0] msg, logic [31:0] now);
    stats_t r;
    logic [31:0] gap;
    logic [63:0] den, pct;
    int n;
    r = '0;
    n = 0;
    if (req == REQ_SWEEP) begin
      for (int i = 0; i < SRC; i++)
        if (valid_tab[i] && pkts_seen > 0 && (now - seen_ms[i]) > timeout_ms) begin
          valid_tab[i] = 0;
          n++;
        end
      r.removed = 9'(n);
      return r;
    end
    if (!valid_tab[id]) begin
      valid_tab[id] = 1;
      last_seq[id] = 0; rcvd_tot[id] = 0; lost_tot[id] = 0;
      rec_rcvd[id] = 0; rec_lost[id] = 0; pct_tab[id] = 0;
      r.created = 1;
    end
    rcvd_tot[id] = add_sat32(rcvd_tot[id], 32'd1);
    seen_ms[id] = now;
    if (pkts_seen < 2) pkts_seen++;
    rec_rcvd[id] = add_sat16(rec_rcvd[id], 32'd1);
    if (msg != RADIO_STATUS_A && msg != RADIO_STATUS_B && pkts_seen >= 2) begin
      gap = 0;
      if (last_seq[id] > seq) gap = seq + 255 - last_seq[id];
      else if (last_seq[id] < seq) gap = seq - last_seq[id] - 1;
      lost_tot[id] = add_sat32(lost_tot[id], gap);
      rec_lost[id] = add_sat16(rec_lost[id], gap);
      if (rcvd_tot[id] % WIN == 0) begin
        den = rec_rcvd[id] + rec_lost[id];
        pct = (64'(rec_lost[id]) * Q8_HUNDRED + den / 2) / den;
        if (pct > Q8_HUNDRED) pct = Q8_HUNDRED;
        pct_tab[id] = pct[14:0];
        rec_lost[id] = 0;
        rec_rcvd[id] = 0;
        r.updated = 1;
      end
    end
    last_seq[id] = seq;
    r.rcvd = rcvd_tot[id];
    r.lost = lost_tot[id];
    r.pct = pct_tab[id];
    return r;
  endfunction

  task automatic send_item(bit req, logic [7:0] id, logic [7:0] seq, logic [23:0] msg,
                           logic [31:0] now);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1;
    s_tuser  <= req;
    s_tdata  <= {now, msg, seq, id};
    do @(posedge clk); while (!s_tready);
    expected_stats = {expected_stats, predict_stats(req, id, seq, msg, now)};
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] v);
    drain_results();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    timeout_ms = v;
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst) m_tready <= !hold_off && !($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    stats_t got, exp_s;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      got.created = m_tuser[0];
      got.updated = m_tuser[1];
      got.rcvd = m_tdata[31:0];
      got.lost = m_tdata[63:32];
      got.pct = m_tdata[78:64];
      got.removed = m_tdata[87:79];
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_s = expected_stats.pop_front();
        if (got !== exp_s) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_s, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  logic [31:0] clock_ms = 0;

  task automatic test_directed();
    send_item(REQ_SWEEP, 8'd0, 8'd0, 24'd0, 32'd0);      // sweep with nothing seen
    send_item(REQ_PACKET, 8'hFF, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF);
    send_item(REQ_PACKET, 8'h00, 8'h00, 24'd0, 32'd0);
    send_item(REQ_PACKET, 8'h00, 8'h05, RADIO_STATUS_A, 32'd1);
    send_item(REQ_PACKET, 8'h00, 8'h09, RADIO_STATUS_B, 32'd2);
    send_item(REQ_PACKET, 8'h00, 8'h03, 24'd1, 32'd3);  // backwards gap
    send_item(REQ_PACKET, 8'h00, 8'h03, 24'd1, 32'd4);  // equal seq
    send_item(REQ_PACKET, 8'hFF, 8'h00, 24'd2, 32'd5);  // wrap gap
    for (int i = 0; i < 29; i++)                          // close a window
      send_item(REQ_PACKET, 8'h00, 8'(4 + 2 * i), 24'd7, 32'd6 + i);
    send_item(REQ_SWEEP, 8'd0, 8'd0, 24'd0, 32'd10035);
    send_item(REQ_SWEEP, 8'd0, 8'd0, 24'd0, 32'd20000);
    send_item(REQ_SWEEP, 8'd0, 8'd0, 24'd0, 32'hFFFF_FFF0);  // wrapped idle time
    clock_ms = 32'hFFFF_FFF0;
  endtask

  task automatic test_random(int count);
    logic [7:0] seqs[4];
    logic [7:0] id;
    for (int i = 0; i < 4; i++) seqs[i] = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      clock_ms += $urandom_range(40);
      if ($urandom_range(99) < 3) begin
        send_item(REQ_SWEEP, 8'($urandom), 8'($urandom), 24'($urandom), clock_ms);
      end else if ($urandom_range(99) < 80) begin
        // few sources, mostly in order, so windows close
        id = 8'($urandom_range(3));
        seqs[id] += ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'd1;
        send_item(REQ_PACKET, {6'd0, id[1:0]} | ($urandom_range(1) ? 8'hFC : 8'h00),
                  seqs[id], ($urandom_range(15) == 0) ? RADIO_STATUS_A : 24'($urandom),
                  clock_ms);
      end else begin
        send_item(REQ_PACKET, 8'($urandom), 8'($urandom),
                  ($urandom_range(9) == 0) ? RADIO_STATUS_B : 24'($urandom), clock_ms);
      end
    end
  endtask

  task automatic test_stall();
    hold_off = 1;
    fork
      repeat (400) @(posedge clk);
      for (int i = 0; i < 6; i++) send_item(REQ_PACKET, 8'(i), 8'(i), 24'd3, clock_ms);
    join_any
    hold_off = 0;
    wait fork;
    drain_results();   // sender pauses until all results arrive
  endtask

  initial begin
    timeout_ms = TIMEOUT_RESET;
    pkts_seen = 0;
    for (int i = 0; i < SRC; i++) begin
      valid_tab[i] = 0; seen_ms[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    write_timeout(32'd1);
    send_item(REQ_SWEEP, 8'd0, 8'd0, 24'd0, clock_ms + 32'd2);
    send_idle_pct = 29; recv_idle_pct = 85;
    test_random(480);
    test_stall();
    write_timeout(32'hFFFF_FFFF);
    send_idle_pct = 85; recv_idle_pct = 29;
    test_random(480);
    write_timeout(32'd50);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(480);
    drain_results();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sslt_pkg.sv
hw/rtl/sslt_div.sv
hw/rtl/source_sequence_loss_tracker.sv
bench/tb.sv
